>>> rtl/core/vtge_pkg.sv
// shared types and constants for the vector tile geometry encoder
package vtge_pkg;

    localparam int RING_MAX_VERTICES_DEF = 32;
    localparam int COORD_FRAC_BITS_DEF   = 16;
    localparam int COORD_W               = 20;
    localparam int EXTENT_W              = 16;
    localparam logic [EXTENT_W-1:0] EXTENT_RESET = 16'd4096;

    localparam logic [3:0] CMD_MOVE  = 4'd9;
    localparam logic [3:0] CMD_LINE  = 4'd10;
    localparam logic [3:0] CMD_CLOSE = 4'd15;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_RING  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // zigzag code of a 32-bit wrapping difference
    function automatic logic [31:0] zigzag(input logic [31:0] d);
        zigzag = {d[30:0], 1'b0} ^ {32{d[31]}};
    endfunction

endpackage

>>> rtl/core/vector_tile_geometry_encoder.sv
// top level of the vector tile geometry encoder
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | geom_kind coord_x coord_y feature_start part_end
//  out      | out_valid / out_ready| command_word zig_dx zig_dy has_deltas
//           |                      | ring_overflow last
//  config   | cfg_we               | cfg_wdata (tile_extent)
//
// a point or line vertex passes capture with scale multiply, a spare state and emit;
// a ring vertex passes capture, area products from the registered ram read of the
// previous vertex, and accumulate. a ring end of n stored vertices then adds a state for
// the closing area term, a ram read, scale and emit per vertex, and a ClosePath beat.
// reset clears control state; the ring ram needs no clearing.
// a stalled output beat holds the sequencer only in S_EMIT and S_OUT, until it is taken.
module vector_tile_geometry_encoder
    import vtge_pkg::*;
#(
    parameter int RING_MAX_VERTICES = RING_MAX_VERTICES_DEF,
    parameter int COORD_FRAC_BITS   = COORD_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  geom_kind,
    input  logic signed [COORD_W-1:0]   coord_x,
    input  logic signed [COORD_W-1:0]   coord_y,
    input  logic                        feature_start,
    input  logic                        part_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [3:0]                  command_word,
    output logic [31:0]                 zig_dx,
    output logic [31:0]                 zig_dy,
    output logic                        has_deltas,
    output logic                        ring_overflow,
    output logic                        last,
    input  logic                        cfg_we,
    input  logic [EXTENT_W-1:0]         cfg_wdata
);
    localparam int AW  = $clog2(RING_MAX_VERTICES);
    localparam int CW  = $clog2(RING_MAX_VERTICES + 1);
    localparam int PW  = COORD_W + EXTENT_W + 1;
    localparam int VW  = 2 * COORD_W;
    localparam logic [CW-1:0] RMAX = CW'(RING_MAX_VERTICES);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCALE  = 9'b000000010,
        S_EMIT   = 9'b000000100,
        S_RAREA  = 9'b000001000,
        S_RACC   = 9'b000010000,
        S_CLOSE  = 9'b000100000,
        S_RREAD  = 9'b001000000,
        S_RSCALE = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [EXTENT_W-1:0] extent_reg;
    logic [CW-1:0]  ring_count_reg;
    logic           ring_number_reg;
    logic [31:0]    cursor_x_reg, cursor_y_reg;
    logic [1:0]     line_index_reg;
    logic           overflow_reg;
    logic signed [47:0] area_reg;

    // captured item
    logic [1:0]     kind_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic           pend_reg;
    logic           kept_reg;
    // scaler
    logic signed [PW-1:0] px_reg, py_reg;
    // replay
    logic [CW-1:0]  rep_i_reg;
    logic           reverse_reg;
    logic           close_phase_reg;
    // output beat
    logic           ov_reg;
    logic [3:0]     cmd_reg;
    logic [31:0]    zx_reg, zy_reg;
    logic           hd_reg, ro_reg, last_reg;
    // area products
    logic signed [40:0] m1_reg, m2_reg;

    // ring ram
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [VW-1:0]  ram_wdata, ram_rdata;
    logic [VW-1:0]  first_reg;

    vtge_ram #(.WIDTH(VW), .DEPTH(RING_MAX_VERTICES)) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // drop the fraction bits of an extent product, truncate toward zero
    function automatic logic [31:0] trunc_scale(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] sh;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        sh  = mag >> COORD_FRAC_BITS;
        trunc_scale = p[PW-1] ? (32'd0 - 32'(sh)) : 32'(sh);
    endfunction

    logic signed [COORD_W-1:0] sel_x, sel_y;
    logic [31:0] sx, sy;
    logic        out_free;
    logic        accept;
    logic [CW-1:0] rep_idx;
    logic [CW-1:0] prev_idx;
    logic signed [COORD_W-1:0] rx, ry, fx, fy, lx, ly;
    logic signed [47:0] area_full;
    logic        line_skip, rep_skip, load_beat;

    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign sx = trunc_scale(px_reg);
    assign sy = trunc_scale(py_reg);
    assign rx = ram_rdata[VW-1:COORD_W];
    assign ry = ram_rdata[COORD_W-1:0];
    assign fx = first_reg[VW-1:COORD_W];
    assign fy = first_reg[COORD_W-1:0];
    // last stored vertex: this one, or the one read back when it was dropped
    assign lx = kept_reg ? cx_reg : rx;
    assign ly = kept_reg ? cy_reg : ry;
    assign prev_idx = ring_count_reg - CW'(1);
    assign rep_idx = reverse_reg ? (ring_count_reg - CW'(1) - rep_i_reg) : rep_i_reg;
    assign area_full = area_reg + 48'(m1_reg) - 48'(m2_reg);

    // repeated vertex checks
    assign line_skip = (line_index_reg == 2'd2) && sx == cursor_x_reg && sy == cursor_y_reg;
    assign rep_skip  = (rep_i_reg > CW'(1)) && sx == cursor_x_reg && sy == cursor_y_reg;

    assign out_valid     = ov_reg;
    assign command_word  = cmd_reg;
    assign zig_dx        = zx_reg;
    assign zig_dy        = zy_reg;
    assign has_deltas    = hd_reg;
    assign ring_overflow = ro_reg;
    assign last          = last_reg;

    // a new output beat is loaded this cycle
    always_comb
    begin
        load_beat = 1'b0;
        if (state_reg == S_EMIT && out_free && (kind_reg == KIND_POINT || !line_skip))
        begin
            load_beat = 1'b1;
        end
        if (state_reg == S_OUT && out_free && (close_phase_reg || !rep_skip))
        begin
            load_beat = 1'b1;
        end
    end

    // ram addressing
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ring_count_reg[AW-1:0];
        ram_wdata = {cx_reg, cy_reg};
        ram_raddr = prev_idx[AW-1:0];
        sel_x     = cx_reg;
        sel_y     = cy_reg;
        if (state_reg == S_RAREA && ring_count_reg < RMAX)
        begin
            ram_we = 1'b1;
        end
        if (state_reg == S_CLOSE || state_reg == S_RREAD || state_reg == S_OUT)
        begin
            ram_raddr = rep_idx[AW-1:0];
        end
        if (state_reg == S_RSCALE)
        begin
            sel_x = rx;
            sel_y = ry;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept && geom_kind != KIND_NONE)
                          state_next = (geom_kind == KIND_RING) ? S_RAREA : S_SCALE;
            S_SCALE:  state_next = S_EMIT;
            S_EMIT:   if (out_free) state_next = S_IDLE;
            S_RAREA:  state_next = S_RACC;
            S_RACC:   state_next = (pend_reg && ring_count_reg != '0) ? S_CLOSE : S_IDLE;
            S_CLOSE:  state_next = S_RREAD;
            S_RREAD:  state_next = S_RSCALE;
            S_RSCALE: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    if (close_phase_reg)
                        state_next = S_IDLE;
                    else if (rep_i_reg + CW'(1) == ring_count_reg)
                        state_next = S_OUT;
                    else
                        state_next = S_RREAD;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // control and data path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            extent_reg      <= EXTENT_RESET;
            ring_count_reg  <= '0;
            ring_number_reg <= 1'b0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            line_index_reg  <= '0;
            overflow_reg    <= 1'b0;
            area_reg        <= '0;
            ov_reg          <= 1'b0;
            rep_i_reg       <= '0;
            close_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                extent_reg <= cfg_wdata;
            end
            if (load_beat)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && geom_kind != KIND_NONE)
                    begin
                        kind_reg <= geom_kind;
                        cx_reg   <= coord_x;
                        cy_reg   <= coord_y;
                        pend_reg <= part_end;
                        px_reg   <= PW'(coord_x) * $signed({1'b0, extent_reg});
                        py_reg   <= PW'(coord_y) * $signed({1'b0, extent_reg});
                        if (feature_start)
                        begin
                            cursor_x_reg    <= '0;
                            cursor_y_reg    <= '0;
                            ring_number_reg <= 1'b0;
                            line_index_reg  <= '0;
                            ring_count_reg  <= '0;
                            area_reg        <= '0;
                            overflow_reg    <= 1'b0;
                        end
                    end
                end
                S_SCALE:
                begin
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (kind_reg == KIND_POINT)
                        begin
                            cmd_reg  <= CMD_MOVE;
                            zx_reg   <= zigzag(sx - cursor_x_reg);
                            zy_reg   <= zigzag(sy - cursor_y_reg);
                            hd_reg   <= 1'b1;
                            ro_reg   <= 1'b0;
                            last_reg <= 1'b1;
                            cursor_x_reg <= sx;
                            cursor_y_reg <= sy;
                        end
                        else
                        begin
                            if (!line_skip)
                            begin
                                cmd_reg  <= (line_index_reg == 2'd0) ? CMD_MOVE : CMD_LINE;
                                zx_reg   <= zigzag(sx - cursor_x_reg);
                                zy_reg   <= zigzag(sy - cursor_y_reg);
                                hd_reg   <= 1'b1;
                                ro_reg   <= 1'b0;
                                last_reg <= 1'b1;
                                cursor_x_reg <= sx;
                                cursor_y_reg <= sy;
                            end
                            if (pend_reg)
                                line_index_reg <= '0;
                            else if (line_index_reg != 2'd2)
                                line_index_reg <= line_index_reg + 2'd1;
                        end
                    end
                end
                S_RAREA:
                begin
                    // previous vertex read lands now
                    if (ring_count_reg < RMAX)
                    begin
                        if (ring_count_reg == '0)
                            first_reg <= {cx_reg, cy_reg};
                        m1_reg <= (ring_count_reg == '0) ? '0 : 41'(rx * cy_reg);
                        m2_reg <= (ring_count_reg == '0) ? '0 : 41'(cx_reg * ry);
                        ring_count_reg <= ring_count_reg + 1'b1;
                        kept_reg       <= 1'b1;
                    end
                    else
                    begin
                        m1_reg       <= '0;
                        m2_reg       <= '0;
                        overflow_reg <= 1'b1;
                        kept_reg     <= 1'b0;
                    end
                end
                S_RACC:
                begin
                    area_reg <= area_full;
                    if (pend_reg && ring_count_reg != '0)
                    begin
                        // closing term from last to first vertex
                        m1_reg <= 41'(lx * fy);
                        m2_reg <= 41'(fx * ly);
                    end
                end
                S_CLOSE:
                begin
                    reverse_reg     <= ring_number_reg != area_full[47];
                    rep_i_reg       <= '0;
                    close_phase_reg <= 1'b0;
                end
                S_RREAD:
                begin
                end
                S_RSCALE:
                begin
                    px_reg <= PW'(sel_x) * $signed({1'b0, extent_reg});
                    py_reg <= PW'(sel_y) * $signed({1'b0, extent_reg});
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        if (close_phase_reg)
                        begin
                            cmd_reg  <= CMD_CLOSE;
                            zx_reg   <= '0;
                            zy_reg   <= '0;
                            hd_reg   <= 1'b0;
                            ro_reg   <= overflow_reg;
                            last_reg <= 1'b1;
                            ring_count_reg  <= '0;
                            area_reg        <= '0;
                            overflow_reg    <= 1'b0;
                            ring_number_reg <= 1'b1;
                        end
                        else
                        begin
                            if (!rep_skip)
                            begin
                                cmd_reg  <= (rep_i_reg == '0) ? CMD_MOVE : CMD_LINE;
                                zx_reg   <= zigzag(sx - cursor_x_reg);
                                zy_reg   <= zigzag(sy - cursor_y_reg);
                                hd_reg   <= 1'b1;
                                ro_reg   <= overflow_reg;
                                last_reg <= 1'b0;
                                cursor_x_reg <= sx;
                                cursor_y_reg <= sy;
                            end
                            rep_i_reg <= rep_i_reg + CW'(1);
                            if (rep_i_reg + CW'(1) == ring_count_reg)
                            begin
                                // closing beat comes next from S_OUT, with no further ram read
                                close_phase_reg <= 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

>>> rtl/core/vtge_ram.sv
// generic single-port-write, one-read ram with registered read
module vtge_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> tb/tb_vector_tile_geometry_encoder.sv
// self-checking testbench for the vector tile geometry encoder
`timescale 1ns / 1ps

module tb_vector_tile_geometry_encoder;
    import vtge_pkg::*;

    localparam int RING_DEPTH  = RING_MAX_VERTICES_DEF;
    localparam int FRAC_BITS   = COORD_FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 120;

    typedef struct {
        logic [1:0]               kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                     fstart;
        logic                     pend;
    } vertex_t;

    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] dx;
        logic [31:0] dy;
        logic        hasd;
        logic        ovf;
        logic        last;
    } command_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                geom_kind = KIND_POINT;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic                      feature_start = 1'b0;
    logic                      part_end = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [3:0]                command_word;
    logic [31:0]               zig_dx;
    logic [31:0]               zig_dy;
    logic                      has_deltas;
    logic                      ring_overflow;
    logic                      last;
    logic                      cfg_we = 1'b0;
    logic [EXTENT_W-1:0]       cfg_wdata = '0;

    vector_tile_geometry_encoder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .geom_kind(geom_kind), .coord_x(coord_x), .coord_y(coord_y),
        .feature_start(feature_start), .part_end(part_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .command_word(command_word), .zig_dx(zig_dx), .zig_dy(zig_dy),
        .has_deltas(has_deltas), .ring_overflow(ring_overflow), .last(last),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vertex_t  vertex_q[$];
    command_t command_q[$];
    vertex_t  held_vertex;
    bit       no_idle = 0;
    bit       hold_go = 0;
    bit       hold_used = 0;
    int       hold_cnt = 0;
    int       mismatches = 0;
    int       beats_in = 0;
    int       beats_out = 0;
    int       rings_replayed = 0;
    int       rings_overflowed = 0;
    int       stall_cycles = 0;

    // encoder state as predicted
    logic [31:0]    cur_x, cur_y;
    int             ring_len;
    bit             ring_inner;
    int             line_pos;
    bit             ring_ovf;
    longint         area_acc;
    longint         ring_x[RING_DEPTH];
    longint         ring_y[RING_DEPTH];
    logic [15:0]    extent;

    function automatic logic [31:0] to_tile(longint c);
        longint p;
        longint mag;
        p = c * longint'(extent);
        if (p < 0)
        begin
            mag = (-p) >>> FRAC_BITS;
            return 32'(-mag);
        end
        return 32'(p >>> FRAC_BITS);
    endfunction

    function automatic logic [31:0] zz_code(logic [31:0] d);
        return (d << 1) ^ (d[31] ? 32'hFFFF_FFFF : 32'h0);
    endfunction

    task automatic push_command(logic [3:0] cmd, logic [31:0] x, logic [31:0] y,
                                logic hasd, logic ovf);
        command_t c;
        c.cmd  = cmd;
        c.dx   = hasd ? zz_code(x - cur_x) : 32'h0;
        c.dy   = hasd ? zz_code(y - cur_y) : 32'h0;
        c.hasd = hasd;
        c.ovf  = ovf;
        c.last = 1'b0;
        command_q = {command_q, c};
        if (hasd)
        begin
            cur_x = x;
            cur_y = y;
        end
    endtask

    task automatic predict_vertex(vertex_t v);
        int          first;
        logic [31:0] sx, sy;
        longint      a;
        bit          rev;
        int          idx;
        first = command_q.size();
        if (v.kind == KIND_NONE)
            return;
        if (v.fstart)
        begin
            cur_x = 0; cur_y = 0;
            ring_inner = 0; line_pos = 0;
            ring_len = 0; area_acc = 0; ring_ovf = 0;
        end
        if (v.kind == KIND_POINT)
        begin
            push_command(CMD_MOVE, to_tile(v.x), to_tile(v.y), 1'b1, 1'b0);
        end
        else if (v.kind == KIND_LINE)
        begin
            sx = to_tile(v.x);
            sy = to_tile(v.y);
            if (!(line_pos >= 2 && sx == cur_x && sy == cur_y))
                push_command(line_pos == 0 ? CMD_MOVE : CMD_LINE, sx, sy, 1'b1, 1'b0);
            if (line_pos < 2)
                line_pos++;
            if (v.pend)
                line_pos = 0;
        end
        else
        begin
            if (ring_len < RING_DEPTH)
            begin
                if (ring_len > 0)
                    area_acc += ring_x[ring_len-1] * longint'(v.y)
                              - longint'(v.x) * ring_y[ring_len-1];
                ring_x[ring_len] = v.x;
                ring_y[ring_len] = v.y;
                ring_len++;
            end
            else
                ring_ovf = 1;
            if (v.pend && ring_len > 0)
            begin
                a = area_acc + ring_x[ring_len-1] * ring_y[0]
                  - ring_x[0] * ring_y[ring_len-1];
                rev = (ring_inner != 0) != (a < 0);
                rings_replayed++;
                if (ring_ovf)
                    rings_overflowed++;
                for (int i = 0; i < ring_len; i++)
                begin
                    idx = rev ? ring_len - 1 - i : i;
                    sx = to_tile(ring_x[idx]);
                    sy = to_tile(ring_y[idx]);
                    if (i > 1 && sx == cur_x && sy == cur_y)
                        continue;
                    push_command(i == 0 ? CMD_MOVE : CMD_LINE, sx, sy, 1'b1, ring_ovf);
                end
                push_command(CMD_CLOSE, 32'h0, 32'h0, 1'b0, ring_ovf);
                ring_len = 0; area_acc = 0; ring_ovf = 0;
                ring_inner = 1;
            end
        end
        if (command_q.size() > first)
            command_q[command_q.size()-1].last = 1'b1;
    endtask

    // driver: offers queued vertices, idles at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_vertex(held_vertex);
                beats_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (vertex_q.size() > 0 && (no_idle || $urandom_range(99) >= 27))
                begin
                    held_vertex   = vertex_q.pop_front();
                    geom_kind     <= held_vertex.kind;
                    coord_x       <= held_vertex.x;
                    coord_y       <= held_vertex.y;
                    feature_start <= held_vertex.fstart;
                    part_end      <= held_vertex.pend;
                    in_valid      <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure, one long hold-off, compare each beat
    always @(posedge clk)
    begin
        command_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (command_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: cmd %0d dx %h dy %h", command_word,
                                 zig_dx, zig_dy);
                end
                else
                begin
                    e = command_q.pop_front();
                    if (command_word !== e.cmd || zig_dx !== e.dx || zig_dy !== e.dy ||
                        has_deltas !== e.hasd || ring_overflow !== e.ovf || last !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp cmd %0d dx %h dy %h hd %b ov %b last %b",
                                     e.cmd, e.dx, e.dy, e.hasd, e.ovf, e.last);
                            $display("          got cmd %0d dx %h dy %h hd %b ov %b last %b",
                                     command_word, zig_dx, zig_dy, has_deltas,
                                     ring_overflow, last);
                        end
                    end
                end
            end
            if (hold_go && !hold_used)
            begin
                hold_used <= 1;
                hold_cnt  <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || $urandom_range(99) >= 27;
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d beats still expected", command_q.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_vertex(logic [1:0] k, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y, logic fs, logic pe);
        vertex_t v;
        v.kind = k; v.x = x; v.y = y; v.fstart = fs; v.pend = pe;
        vertex_q = {vertex_q, v};
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        int m;
        m = $urandom_range(9);
        if (m < 4)
            return COORD_W'($urandom);
        if (m < 8)
            return COORD_W'($signed($urandom_range(16'hFFFF, 0)) - 32768) <<< 2;
        if (m == 8)
            return 20'sh80000;
        return 20'sh7FFFF;
    endfunction

    // one random feature; returns the number of vertices queued
    task automatic add_feature(output int count);
        int sel, parts, nv;
        logic signed [COORD_W-1:0] px, py;
        bit dup;
        count = 0;
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            parts = $urandom_range(4, 1);
            for (int i = 0; i < parts; i++)
            begin
                add_vertex(KIND_POINT, pick_coord(), pick_coord(), i == 0,
                           1'($urandom_range(1)));
                count++;
            end
        end
        else if (sel < 45)
        begin
            parts = $urandom_range(3, 1);
            for (int p = 0; p < parts; p++)
            begin
                nv = $urandom_range(6, 1);
                for (int i = 0; i < nv; i++)
                begin
                    dup = i > 0 && $urandom_range(3) == 0;
                    if (!dup)
                    begin
                        px = pick_coord();
                        py = pick_coord();
                    end
                    add_vertex(KIND_LINE, px, py, p == 0 && i == 0, i == nv - 1);
                    count++;
                end
            end
        end
        else if (sel < 90)
        begin
            parts = $urandom_range(3, 1);
            for (int p = 0; p < parts; p++)
            begin
                nv = ($urandom_range(24) == 0) ? $urandom_range(40, 33) : $urandom_range(8, 1);
                for (int i = 0; i < nv; i++)
                begin
                    dup = i > 0 && ($urandom_range(4) == 0 || nv == 4);
                    if (!dup)
                    begin
                        px = pick_coord();
                        py = pick_coord();
                    end
                    add_vertex(KIND_RING, px, py, p == 0 && i == 0, i == nv - 1);
                    count++;
                end
            end
        end
        else
        begin
            // noise: ignored items, stray flags, a ring left unfinished
            nv = $urandom_range(5, 1);
            for (int i = 0; i < nv; i++)
            begin
                add_vertex(2'($urandom_range(3)), pick_coord(), pick_coord(),
                           1'($urandom_range(1)), $urandom_range(3) == 0);
                count++;
            end
            add_vertex(KIND_RING, pick_coord(), pick_coord(), 1'b1, 1'b0);
            add_vertex(KIND_RING, pick_coord(), pick_coord(), 1'b0, 1'b0);
            count += 2;
        end
    endtask

    task automatic add_random(int target);
        int done, n;
        done = 0;
        while (done < target)
        begin
            add_feature(n);
            done += n;
        end
    endtask

    task automatic wait_drained();
        wait (vertex_q.size() == 0 && !in_valid && command_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_extent(logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        extent = value;
    endtask

    // stimulus sequence
    initial
    begin
        logic [15:0] ext_list[5];
        cur_x = 0; cur_y = 0; ring_len = 0; ring_inner = 0; line_pos = 0;
        ring_ovf = 0; area_acc = 0; extent = EXTENT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every kind, duplicates, ignored items, ring reset
        add_vertex(KIND_POINT, 20'sh7FFFF, 20'sh80000, 1'b1, 1'b0);
        add_vertex(KIND_POINT, 20'sh80000, 20'sh7FFFF, 1'b0, 1'b1);
        add_vertex(KIND_POINT, 20'sh00000, 20'shFFFFF, 1'b1, 1'b0);
        add_vertex(KIND_LINE, 20'sh10000, 20'sh10000, 1'b1, 1'b0);
        add_vertex(KIND_LINE, 20'sh20000, 20'sh10000, 1'b0, 1'b0);
        add_vertex(KIND_LINE, 20'sh20000, 20'sh10000, 1'b0, 1'b0);
        add_vertex(KIND_LINE, 20'sh30000, 20'sh20000, 1'b0, 1'b1);
        add_vertex(KIND_LINE, 20'sh30000, 20'sh20000, 1'b0, 1'b0);
        add_vertex(KIND_LINE, 20'sh30000, 20'sh20000, 1'b0, 1'b1);
        add_vertex(KIND_NONE, 20'sh7FFFF, 20'sh7FFFF, 1'b1, 1'b1);
        add_vertex(KIND_RING, 20'sh00000, 20'sh00000, 1'b1, 1'b0);
        add_vertex(KIND_RING, 20'sh10000, 20'sh00000, 1'b0, 1'b0);
        add_vertex(KIND_RING, 20'sh10000, 20'sh10000, 1'b0, 1'b1);
        add_vertex(KIND_RING, 20'sh04000, 20'sh04000, 1'b0, 1'b0);
        add_vertex(KIND_RING, 20'sh08000, 20'sh04000, 1'b0, 1'b0);
        add_vertex(KIND_RING, 20'sh08000, 20'sh08000, 1'b0, 1'b1);
        add_vertex(KIND_RING, 20'sh01000, 20'sh01000, 1'b1, 1'b0);
        add_vertex(KIND_RING, 20'sh02000, 20'sh02000, 1'b0, 1'b0);
        add_vertex(KIND_RING, 20'sh05000, 20'sh05000, 1'b1, 1'b0);
        add_vertex(KIND_RING, 20'sh05000, 20'sh05000, 1'b0, 1'b0);
        add_vertex(KIND_RING, 20'sh05000, 20'sh05000, 1'b0, 1'b1);
        add_vertex(KIND_RING, 20'sh7FFFF, 20'sh80000, 1'b0, 1'b1);
        wait_drained();

        // reset extent, receiver holds off long while the sender keeps going
        hold_go = 1;
        add_random(60);
        wait_drained();

        ext_list = '{16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(65535, 1)), EXTENT_RESET};
        foreach (ext_list[i])
        begin
            write_extent(ext_list[i]);
            no_idle = (i == 3);
            add_random(55);
            wait_drained();
        end
        no_idle = 0;

        $display("%0d vertex beats in, %0d command beats out", beats_in, beats_out);
        $display("%0d rings replayed (%0d overflowed); extents: reset, max, one, zero, random",
                 rings_replayed, rings_overflowed);
        if (mismatches == 0 && command_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/vtge_pkg.sv
rtl/core/vtge_ram.sv
rtl/core/vector_tile_geometry_encoder.sv
tb/tb_vector_tile_geometry_encoder.sv
